/* hdl/matrix_vector_transform_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the vertex transform core
// Shared concurrent property forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_TRANSFORM_CORE_ASSERT_SVH
`define MATRIX_VECTOR_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication
`define MVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mvt_pkg.sv */
// ---------------------------------------------------------------------------
// mvt_pkg
// Types and codes shared by the vertex transform core.
// ---------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

	localparam int DIM   = 4;
	localparam int ELEMS = DIM * DIM;

	typedef logic signed [31:0] word_t;
	typedef logic signed [63:0] prod_t;
	typedef logic signed [65:0] sum_t;
	typedef logic [3:0]         elem_idx_t;
	typedef logic [1:0]         op_t;

	localparam op_t OP_LOAD = 2'd0;
	localparam op_t OP_VEC4 = 2'd1;
	localparam op_t OP_VEC3 = 2'd2;

	typedef struct packed {
		logic valid;
		logic vec3;
	} stage_ctl_t;

endpackage

`default_nettype wire

/* hdl/matrix_vector_transform_core.sv */
// ---------------------------------------------------------------------------
// matrix_vector_transform_core
// 4x4 Q16.16 vertex transform with a loadable column-major matrix.
// ---------------------------------------------------------------------------
// Item channel (item_valid / item_stall): op selects a matrix element load,
// a vec4 transform or a vec3 transform (w taken as one, rw returned as zero).
// Loads write the matrix at the accepting edge and give no result beat;
// op 3 is dropped. Later transforms always see every earlier load.
// Result channel (result_valid / result_stall): rx, ry, rz, rw and overflow.
// A transform passes the first-stage, product, row-sum and output registers.
// Throughput: one item per cycle while not stalled; the sixteen multipliers
// sit in one stage, the row sums in the next, shift and saturation before the
// output register. Empty stages fill while a result waits; item_stall rises
// only when every stage and the output register hold a beat and result_stall
// is high. Reset clears all stage valids and restores the identity matrix.
// ---------------------------------------------------------------------------
`default_nettype none

`include "matrix_vector_transform_core_assert.svh"

module matrix_vector_transform_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         op,
	input  logic [3:0]         elem_index,
	input  logic signed [31:0] elem_value,
	input  logic signed [31:0] vx,
	input  logic signed [31:0] vy,
	input  logic signed [31:0] vz,
	input  logic signed [31:0] vw,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic signed [31:0] rw,
	output logic               overflow
);

	localparam mvt_pkg::word_t ONE = mvt_pkg::word_t'(longint'(1) << FRAC_BITS);

	logic                en_out, en3, en2, en1;
	logic                accept, load, xform;
	mvt_pkg::stage_ctl_t ctl_s1, ctl_s2, ctl_s3;
	mvt_pkg::word_t      v_s1 [mvt_pkg::DIM];
	mvt_pkg::word_t      mat [mvt_pkg::ELEMS];
	mvt_pkg::prod_t      prod_s2 [mvt_pkg::ELEMS];
	mvt_pkg::word_t      res [mvt_pkg::DIM];
	logic [3:0]          ovf;

	logic                valid_q, vec3_q, overflow_q;
	mvt_pkg::word_t      rx_q, ry_q, rz_q, rw_q;

	// advance each stage when empty or when the next one moves
	assign en_out     = !valid_q || !result_stall;
	assign en3        = !ctl_s3.valid || en_out;
	assign en2        = !ctl_s2.valid || en3;
	assign en1        = !ctl_s1.valid || en2;
	assign item_stall = !en1;

	assign accept = item_valid && !item_stall;
	assign load   = accept && (op == mvt_pkg::OP_LOAD);
	assign xform  = (op == mvt_pkg::OP_VEC4) || (op == mvt_pkg::OP_VEC3);

	mvt_matrix #(
		.FRAC_BITS(FRAC_BITS)
	) u_matrix (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (load),
		.widx  (elem_index),
		.wdata (elem_value),
		.mat   (mat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en1) begin
			ctl_s1.valid <= accept && xform;
			ctl_s1.vec3  <= op == mvt_pkg::OP_VEC3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			v_s1[0] <= vx;
			v_s1[1] <= vy;
			v_s1[2] <= vz;
			v_s1[3] <= (op == mvt_pkg::OP_VEC3) ? ONE : vw;
		end
	end

	mvt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en2),
		.ctl_s1 (ctl_s1),
		.v_s1   (v_s1),
		.mat    (mat),
		.ctl_s2 (ctl_s2),
		.prod_s2(prod_s2)
	);

	mvt_reduce #(
		.FRAC_BITS(FRAC_BITS)
	) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en3),
		.ctl_s2 (ctl_s2),
		.prod_s2(prod_s2),
		.ctl_s3 (ctl_s3),
		.res    (res),
		.ovf    (ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vec3_q  <= 1'b0;
		end else if (en_out) begin
			valid_q <= ctl_s3.valid;
			vec3_q  <= ctl_s3.vec3;
		end
	end

	// drop the w row for vec3
	always_ff @(posedge clk) begin
		if (en_out) begin
			rx_q       <= res[0];
			ry_q       <= res[1];
			rz_q       <= res[2];
			rw_q       <= ctl_s3.vec3 ? '0 : res[3];
			overflow_q <= (|ovf[2:0]) || (!ctl_s3.vec3 && ovf[3]);
		end
	end

	assign result_valid = valid_q;
	assign rx           = rx_q;
	assign ry           = ry_q;
	assign rz           = rz_q;
	assign rw           = rw_q;
	assign overflow     = overflow_q;

	`MVT_ASSERT_NOW(a_vec3_w_zero, valid_q && vec3_q, rw_q == '0, "vec3 result with nonzero w")

	`MVT_ASSERT_NEXT(a_load_written, load, mat[$past(elem_index)] == $past(elem_value), "matrix load lost")

	`MVT_ASSERT_NEXT(a_xform_enters, accept && xform, ctl_s1.valid, "accepted transform not in first stage")

	`MVT_ASSERT_NEXT(a_load_no_beat, accept && !xform, !ctl_s1.valid, "load or unused op made a beat")

endmodule

`default_nettype wire

/* hdl/mvt_matrix.sv */
// ---------------------------------------------------------------------------
// mvt_matrix
// 4x4 column-major element store, reset to identity, one write per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module mvt_matrix #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  mvt_pkg::elem_idx_t  widx,
	input  mvt_pkg::word_t      wdata,
	output mvt_pkg::word_t      mat [mvt_pkg::ELEMS]
);

	localparam mvt_pkg::word_t ONE = mvt_pkg::word_t'(longint'(1) << FRAC_BITS);

	mvt_pkg::word_t mat_q [mvt_pkg::ELEMS];

	for (genvar g = 0; g < mvt_pkg::ELEMS; g++) begin : g_elem
		localparam bit DIAG = (g / mvt_pkg::DIM) == (g % mvt_pkg::DIM);
		localparam mvt_pkg::elem_idx_t IDX = mvt_pkg::elem_idx_t'(g);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mat_q[g] <= DIAG ? ONE : '0;
			end else if (we && widx == IDX) begin
				mat_q[g] <= wdata;
			end
		end

		assign mat[g] = mat_q[g];
	end

endmodule

`default_nettype wire

/* hdl/mvt_mul.sv */
// ---------------------------------------------------------------------------
// mvt_mul
// Sixteen element-by-component products, registered at full width.
// ---------------------------------------------------------------------------
`default_nettype none

module mvt_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  mvt_pkg::stage_ctl_t  ctl_s1,
	input  mvt_pkg::word_t       v_s1 [mvt_pkg::DIM],
	input  mvt_pkg::word_t       mat [mvt_pkg::ELEMS],
	output mvt_pkg::stage_ctl_t  ctl_s2,
	output mvt_pkg::prod_t       prod_s2 [mvt_pkg::ELEMS]
);

	mvt_pkg::prod_t prod_d [mvt_pkg::ELEMS];

	// element (r, c) sits at c*4 + r and meets component c
	for (genvar g = 0; g < mvt_pkg::ELEMS; g++) begin : g_prod
		assign prod_d[g] = mvt_pkg::prod_t'(mat[g]) *
			mvt_pkg::prod_t'(v_s1[g / mvt_pkg::DIM]);

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s2[g] <= prod_d[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

endmodule

`default_nettype wire

/* hdl/mvt_reduce.sv */
// ---------------------------------------------------------------------------
// mvt_reduce
// Row sums of the products, then floor shift and saturation to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module mvt_reduce #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  mvt_pkg::stage_ctl_t  ctl_s2,
	input  mvt_pkg::prod_t       prod_s2 [mvt_pkg::ELEMS],
	output mvt_pkg::stage_ctl_t  ctl_s3,
	output mvt_pkg::word_t       res [mvt_pkg::DIM],
	output logic [3:0]           ovf
);

	localparam mvt_pkg::word_t WMAX = mvt_pkg::word_t'(32'h7fff_ffff);
	localparam mvt_pkg::word_t WMIN = mvt_pkg::word_t'(32'h8000_0000);

	mvt_pkg::sum_t sum_s3 [mvt_pkg::DIM];

	for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
		mvt_pkg::sum_t sum_d;
		mvt_pkg::sum_t shifted;
		logic          fits;

		assign sum_d = mvt_pkg::sum_t'(prod_s2[r])
			+ mvt_pkg::sum_t'(prod_s2[mvt_pkg::DIM + r])
			+ mvt_pkg::sum_t'(prod_s2[2 * mvt_pkg::DIM + r])
			+ mvt_pkg::sum_t'(prod_s2[3 * mvt_pkg::DIM + r]);

		always_ff @(posedge clk) begin
			if (en) begin
				sum_s3[r] <= sum_d;
			end
		end

		assign shifted = sum_s3[r] >>> FRAC_BITS;
		assign fits    = (&shifted[65:31]) || !(|shifted[65:31]);
		assign ovf[r]  = !fits;
		assign res[r]  = fits ? shifted[31:0] : (shifted[65] ? WMIN : WMAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

endmodule

`default_nettype wire

/* verif/mvt_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvt_checker
// Watches the item and result channels of the vertex transform core, keeps
// its own copy of the column-major matrix and predicts each transform in
// signed Q16.16 with exact sums, floor shift and 32-bit saturation. Result
// beats are compared in order against the predictions.
// ---------------------------------------------------------------------------
module mvt_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [1:0]         op,
	input  logic [3:0]         elem_index,
	input  logic signed [31:0] elem_value,
	input  logic signed [31:0] vx,
	input  logic signed [31:0] vy,
	input  logic signed [31:0] vz,
	input  logic signed [31:0] vw,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic signed [31:0] rx,
	input  logic signed [31:0] ry,
	input  logic signed [31:0] rz,
	input  logic signed [31:0] rw,
	input  logic               overflow,
	output int                 fail_count,
	output int                 pending
);

	import mvt_pkg::*;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		word_t w;
		logic  ovf;
	} vertex_t;

	localparam sum_t  WORD_MAX = 66'sh7FFF_FFFF;
	localparam sum_t  WORD_MIN = -66'sh8000_0000;
	localparam word_t UNIT     = 32'sd1 <<< FRAC_BITS;

	word_t   matrix [ELEMS];
	vertex_t vertex_q [$];
	int      fails = 0;

	// {saturated, value} of one row of M * v
	function automatic logic [32:0] row_dot(input int row, input word_t a, input word_t b,
			input word_t c, input word_t d);
		sum_t acc;
		sum_t q;
		acc = matrix[row] * a + matrix[4 + row] * b + matrix[8 + row] * c
			+ matrix[12 + row] * d;
		q = acc >>> FRAC_BITS;
		if (q > WORD_MAX)
			return {1'b1, 32'h7FFF_FFFF};
		if (q < WORD_MIN)
			return {1'b1, 32'h8000_0000};
		return {1'b0, q[31:0]};
	endfunction

	function automatic vertex_t transform(input op_t kind, input word_t a, input word_t b,
			input word_t c, input word_t d);
		vertex_t     t;
		logic [32:0] r0, r1, r2, r3;
		word_t       w_in;
		w_in = (kind == OP_VEC3) ? UNIT : d;
		r0 = row_dot(0, a, b, c, w_in);
		r1 = row_dot(1, a, b, c, w_in);
		r2 = row_dot(2, a, b, c, w_in);
		r3 = row_dot(3, a, b, c, w_in);
		t.x = r0[31:0];
		t.y = r1[31:0];
		t.z = r2[31:0];
		if (kind == OP_VEC3) begin
			t.w   = '0;
			t.ovf = r0[32] | r1[32] | r2[32];
		end else begin
			t.w   = r3[31:0];
			t.ovf = r0[32] | r1[32] | r2[32] | r3[32];
		end
		return t;
	endfunction

	task automatic check_field(input string name, input word_t want, input word_t got);
		if (want !== got) begin
			fails++;
			$display("%0t ns %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			for (int i = 0; i < ELEMS; i++)
				matrix[i] = (i % 5 == 0) ? UNIT : '0;
			vertex_q.delete();
		end else begin
			if (item_valid && !item_stall) begin
				case (op)
					OP_LOAD: matrix[elem_index] = elem_value;
					OP_VEC4, OP_VEC3: vertex_q.push_back(transform(op, vx, vy, vz, vw));
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (vertex_q.size() == 0) begin
					fails++;
					$display("%0t ns unexpected result beat: expected none actual %h %h %h %h %b",
						$time, rx, ry, rz, rw, overflow);
				end else begin
					want = vertex_q.pop_front();
					check_field("rx", want.x, rx);
					check_field("ry", want.y, ry);
					check_field("rz", want.z, rz);
					check_field("rw", want.w, rw);
					check_field("overflow", word_t'(want.ovf), word_t'(overflow));
				end
			end
		end
		fail_count <= fails;
		pending    <= vertex_q.size();
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives the vertex transform core with directed loads and transforms at
// the numeric extremes, then random load, vec4, vec3 and dropped beats
// under three idle and stall mixes, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_top;

	import mvt_pkg::*;

	localparam int    FRAC_BITS       = 16;
	localparam int    ITEMS_PER_PHASE = 500;
	localparam int    CYCLE_LIMIT     = 200000;
	localparam int    DRAIN_CYCLES    = 8;
	localparam op_t   OP_UNUSED       = 2'd3;
	localparam word_t ONE             = 32'sh0001_0000;
	localparam word_t WMAX            = 32'sh7FFF_FFFF;
	localparam word_t WMIN            = 32'sh8000_0000;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	op_t       op           = OP_LOAD;
	elem_idx_t elem_index   = '0;
	word_t     elem_value   = '0;
	word_t     vx           = '0;
	word_t     vy           = '0;
	word_t     vz           = '0;
	word_t     vw           = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	word_t     rx, ry, rz, rw;
	logic      overflow;
	int        fail_count;
	int        pending;
	int        cycles       = 0;
	int        idle_pct     = 0;
	int        stall_pct    = 0;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles       <= cycles + 1;
		result_stall <= ($urandom_range(0, 99) < stall_pct);
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	matrix_vector_transform_core #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.op          (op),
		.elem_index  (elem_index),
		.elem_value  (elem_value),
		.vx          (vx),
		.vy          (vy),
		.vz          (vz),
		.vw          (vw),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.rx          (rx),
		.ry          (ry),
		.rz          (rz),
		.rw          (rw),
		.overflow    (overflow)
	);

	mvt_checker #(.FRAC_BITS(FRAC_BITS)) mvt_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.op          (op),
		.elem_index  (elem_index),
		.elem_value  (elem_value),
		.vx          (vx),
		.vy          (vy),
		.vz          (vz),
		.vw          (vw),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.rx          (rx),
		.ry          (ry),
		.rz          (rz),
		.rw          (rw),
		.overflow    (overflow),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	function automatic word_t any_word();
		case ($urandom_range(0, 9))
			0: return WMAX;
			1: return WMIN;
			2: return '0;
			3: return ONE;
			4: return -32'sd1;
			5, 6: return word_t'($urandom);
			default: return word_t'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
		endcase
	endfunction

	task automatic send(input op_t kind, input elem_idx_t idx, input word_t value,
			input word_t x, input word_t y, input word_t z, input word_t w);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		op         <= kind;
		elem_index <= idx;
		elem_value <= value;
		vx         <= x;
		vy         <= y;
		vz         <= z;
		vw         <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic send_load(input elem_idx_t idx, input word_t value);
		send(OP_LOAD, idx, value, word_t'($urandom), word_t'($urandom), word_t'($urandom),
			word_t'($urandom));
	endtask

	task automatic send_vec(input op_t kind, input word_t x, input word_t y, input word_t z,
			input word_t w);
		send(kind, elem_idx_t'($urandom), word_t'($urandom), x, y, z, w);
	endtask

	initial begin
		int sent;
		int pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 27;
		stall_pct <= 52;

		// identity pass-through at the extremes, dropped op
		send_vec(OP_VEC4, WMAX, WMIN, '0, -32'sd1);
		send_vec(OP_VEC3, WMIN, WMAX, 32'sd1, 32'sh1234_5678);
		send(OP_UNUSED, elem_idx_t'($urandom), word_t'($urandom), word_t'($urandom),
			word_t'($urandom), word_t'($urandom), word_t'($urandom));
		// translation column, saturating z
		send_load(4'd12, 32'sh0003_0000);
		send_load(4'd13, -32'sh0002_0000);
		send_load(4'd14, WMAX);
		send_vec(OP_VEC3, ONE, ONE, WMAX, '0);
		send_vec(OP_VEC4, ONE, ONE, WMAX, '0);
		send_load(4'd12, '0);
		send_load(4'd13, '0);
		send_load(4'd14, '0);
		// saturation both ways
		send_load(4'd0, WMAX);
		send_vec(OP_VEC4, WMAX, '0, '0, '0);
		send_vec(OP_VEC4, WMIN, '0, '0, '0);
		// w row saturates: ignored for vec3, counted for vec4
		send_load(4'd0, ONE);
		send_load(4'd3, WMAX);
		send_vec(OP_VEC3, WMAX, '0, '0, WMAX);
		send_vec(OP_VEC4, WMAX, '0, '0, '0);
		// floor on negative fractions
		send_load(4'd5, 32'sd1);
		send_vec(OP_VEC4, '0, -32'sd1, '0, '0);
		send_vec(OP_VEC4, '0, 32'sd1, '0, '0);
		// most negative squared
		send_load(4'd10, WMIN);
		send_vec(OP_VEC4, '0, '0, WMIN, '0);

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 52 : 0;
			stall_pct <= (phase == 0) ? 52 : (phase == 1) ? 27 : 0;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					send_load(elem_idx_t'($urandom), any_word());
					sent++;
				end else if (pick < 95) begin
					send_vec((pick < 60) ? OP_VEC4 : OP_VEC3, any_word(), any_word(),
						any_word(), any_word());
					sent++;
				end else begin
					send(OP_UNUSED, elem_idx_t'($urandom), word_t'($urandom),
						word_t'($urandom), word_t'($urandom), word_t'($urandom),
						word_t'($urandom));
				end
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending != 0)
			$display("%0t ns %0d expected results never arrived", $time, pending);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
